// ----- hw/rtl/bdlp_pkg.sv -----
// shared types and constants for the button debounce and long-press block
package bdlp_pkg;

  // widths of the fixed fields
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned PIN_W       = 8;
  localparam int unsigned MASK_W      = 3;
  localparam int unsigned MAX_BUTTONS = 4;
  localparam int unsigned PIN_BASE    = 4;
  localparam int unsigned OUT_W       = 8;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;

  // register reset values
  localparam logic [TICK_W-1:0] SETTLE_RESET = 16'd50;
  localparam logic [TICK_W-1:0] LONG_RESET   = 16'd1000;

  // register indexes (byte address bit 2)
  localparam logic REG_SETTLE = 1'b0;
  localparam logic REG_LONG   = 1'b1;

  // item kinds carried on tuser
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // per-button phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_DOWN   = 2'd2,
    PH_HELD   = 2'd3
  } bdlp_phase_t;

  // control shared by all lanes
  typedef struct packed {
    logic              fire;
    logic              tick;
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] long_ticks;
  } bdlp_ctrl_t;

endpackage

// ----- hw/rtl/button_debounce_long_press.sv -----
// top level: config registers, one lane per button and the result merge
//
// Debounces BUTTONS active-low buttons (pin_byte bits 4 and up) and qualifies
// long presses. Every item, scan or tick, yields one result with the down and
// long masks as they stand after that item. The block takes one item per clock
// cycle while in_tready is high: each button has its own lane with a shallow
// phase machine and a 16-bit countdown, all lanes update in the cycle the item
// is accepted, and the result is registered onto out_tdata. A two-entry output
// buffer lets the block keep accepting while a result waits; in_tready drops
// only when both entries are full. Registers: settle_ticks at byte address 0,
// long_press_ticks at byte address 4, both 16 bits in a 32-bit word.
module button_debounce_long_press #(
  parameter int unsigned BUTTONS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bdlp_pkg::PIN_W-1:0]    in_tdata,   // [7:0] pin_byte
  input  logic                          in_tuser,   // [0] action
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bdlp_pkg::OUT_W-1:0]    out_tdata,  // [2:0] down_mask, [5:3] long_mask
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bdlp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bdlp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bdlp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [bdlp_pkg::TICK_W-1:0] settle_r, settle_nxt;
  logic [bdlp_pkg::TICK_W-1:0] long_r, long_nxt;
  logic                        cfg_wr;
  logic                        in_fire;
  bdlp_pkg::bdlp_ctrl_t        ctrl;
  logic [BUTTONS-1:0]          down_flags, long_flags;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    settle_nxt = settle_r;
    long_nxt   = long_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        bdlp_pkg::REG_SETTLE: settle_nxt = cfg_pwdata[bdlp_pkg::TICK_W-1:0];
        bdlp_pkg::REG_LONG:   long_nxt   = cfg_pwdata[bdlp_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= bdlp_pkg::SETTLE_RESET;
      long_r   <= bdlp_pkg::LONG_RESET;
    end else begin
      settle_r <= settle_nxt;
      long_r   <= long_nxt;
    end
  end

  // read back
  always_comb begin
    case (cfg_paddr[2])
      bdlp_pkg::REG_SETTLE: cfg_prdata = bdlp_pkg::CFG_DW'(settle_r);
      bdlp_pkg::REG_LONG:   cfg_prdata = bdlp_pkg::CFG_DW'(long_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // lane control
  assign in_fire           = in_tvalid && in_tready;
  assign ctrl.fire         = in_fire;
  assign ctrl.tick         = (in_tuser == bdlp_pkg::ACT_TICK);
  assign ctrl.settle_ticks = settle_r;
  assign ctrl.long_ticks   = long_r;

  // one lane per button
  for (genvar n = 0; n < BUTTONS; n++) begin : g_lane
    bdlp_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pressed  (!in_tdata[bdlp_pkg::PIN_BASE + n]),
      .down_nxt (down_flags[n]),
      .long_nxt (long_flags[n])
    );
  end

  // mask merge and output buffer
  bdlp_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .down_flags (down_flags),
    .long_flags (long_flags),
    .accept_ok  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a long press is only ever reported on a button that is also down
  a_long_implies_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[5:3] & ~out_tdata[2:0]) == 3'b000))
    else $error("long_mask bit set without down_mask bit");

  // backpressure only while results are pending
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a settle_ticks write lands in the register
  a_cfg_settle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[2] == bdlp_pkg::REG_SETTLE))
      |=> (settle_r == $past(cfg_pwdata[bdlp_pkg::TICK_W-1:0])))
    else $error("settle_ticks write lost");

endmodule

// ----- hw/rtl/bdlp_lane.sv -----
// one button lane: phase machine, countdown timer and down/long flags
module bdlp_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  bdlp_pkg::bdlp_ctrl_t ctrl,
  input  logic                pressed,
  output logic                down_nxt,
  output logic                long_nxt
);

  bdlp_pkg::bdlp_phase_t           phase_r, phase_nxt;
  logic [bdlp_pkg::TICK_W-1:0]     timer_r, timer_nxt;
  logic                            down_r, long_r;
  logic                            timer_zero;

  assign timer_zero = (timer_r == '0);

  // state, timer and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bdlp_pkg::PH_IDLE;
      timer_r <= '0;
      down_r  <= 1'b0;
      long_r  <= 1'b0;
    end else if (ctrl.fire) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      down_r  <= down_nxt;
      long_r  <= long_nxt;
    end
  end

  // next phase, timer and flags for the current item
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    down_nxt  = down_r;
    long_nxt  = long_r;
    if (ctrl.tick) begin
      // count down, stop at zero
      if (!timer_zero) begin
        timer_nxt = timer_r - 16'd1;
      end
    end else begin
      case (phase_r)
        bdlp_pkg::PH_IDLE: begin
          // lockout while the idle timer runs
          if (timer_zero) begin
            if (pressed) begin
              timer_nxt = ctrl.settle_ticks;
              phase_nxt = bdlp_pkg::PH_SETTLE;
            end else begin
              down_nxt = 1'b0;
              long_nxt = 1'b0;
            end
          end
        end
        bdlp_pkg::PH_SETTLE: begin
          if (!pressed) begin
            phase_nxt = bdlp_pkg::PH_IDLE;
            down_nxt  = 1'b0;
            long_nxt  = 1'b0;
          end else if (timer_zero) begin
            timer_nxt = ctrl.long_ticks;
            phase_nxt = bdlp_pkg::PH_DOWN;
            down_nxt  = 1'b1;
          end
        end
        bdlp_pkg::PH_DOWN: begin
          if (!pressed) begin
            phase_nxt = bdlp_pkg::PH_IDLE;
            down_nxt  = 1'b0;
            long_nxt  = 1'b0;
          end else if (timer_zero) begin
            phase_nxt = bdlp_pkg::PH_HELD;
            long_nxt  = 1'b1;
          end
        end
        default: begin
          if (!pressed) begin
            phase_nxt = bdlp_pkg::PH_IDLE;
            down_nxt  = 1'b0;
            long_nxt  = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bdlp_merge.sv -----
// merges lane flags into result masks and buffers items in a two-entry skid
module bdlp_merge #(
  parameter int unsigned BUTTONS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [BUTTONS-1:0]           down_flags,
  input  logic [BUTTONS-1:0]           long_flags,
  output logic                         accept_ok,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bdlp_pkg::OUT_W-1:0]   out_tdata
);

  logic [bdlp_pkg::MAX_BUTTONS-1:0] down_pad, long_pad;
  logic [bdlp_pkg::OUT_W-1:0]       item_data;
  logic                             main_v_r, main_v_nxt;
  logic                             skid_v_r, skid_v_nxt;
  logic [bdlp_pkg::OUT_W-1:0]       main_d_r, main_d_nxt;
  logic [bdlp_pkg::OUT_W-1:0]       skid_d_r, skid_d_nxt;

  // pack the masks: down_mask low, long_mask above, zero fill
  assign down_pad  = bdlp_pkg::MAX_BUTTONS'(down_flags);
  assign long_pad  = bdlp_pkg::MAX_BUTTONS'(long_flags);
  assign item_data = bdlp_pkg::OUT_W'({long_pad[bdlp_pkg::MASK_W-1:0],
                                       down_pad[bdlp_pkg::MASK_W-1:0]});

  assign accept_ok  = !skid_v_r;
  assign out_tvalid = main_v_r;
  assign out_tdata  = main_d_r;

  // buffer control
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || out_tready) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = fire;
        main_d_nxt = item_data;
      end
    end else if (fire) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule
